### hdl/skit_pkg.sv
// skit_pkg: shared types and constants of the sorted key insert table
// holds field widths, parameter defaults, command and status codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package skit_pkg;

  // fixed field widths of the ports
  localparam int KEY_W    = 16;
  localparam int HANDLE_W = 16;
  localparam int RANK_W   = 6;
  localparam int COUNT_W  = 7;

  // parameter defaults
  localparam int CAPACITY_DEF    = 64;
  localparam int KEY_BITS_DEF    = 16;
  localparam int HANDLE_BITS_DEF = 16;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // function codes of an input item
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_PLAIN  = 2'd0,   // result only, no table access
    CMD_READ   = 2'd1,
    CMD_INSERT = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    status_e   status;
    logic      empty;    // insert into an empty table
    logic      last;     // batch marker echoed in the result
  } cmd_t;

endpackage

`default_nettype wire

### hdl/skit_ram.sv
// skit_ram: generic single write, single read memory with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module skit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/skit_front.sv
// skit_front: accepts items, classifies them against the running count
// and queues commands for the back end; depends on skit_pkg
`timescale 1ns / 1ps
`default_nettype none

module skit_front
  import skit_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   func_i,
  input  wire logic [KEY_W-1:0]       entry_key_i,
  input  wire logic [HANDLE_W-1:0]    entry_handle_i,
  input  wire logic [RANK_W-1:0]      rank_i,
  input  wire logic                   batch_last_i,
  output logic                        cmd_valid_o,
  input  wire logic                   cmd_pop_i,
  output cmd_t                        cmd_o,
  output logic      [KEY_BITS-1:0]    cmd_key_o,
  output logic      [HANDLE_BITS-1:0] cmd_handle_o,
  output logic      [CW-1:0]          cmd_cnt_o,
  output logic      [AW-1:0]          cmd_addr_o
);

  localparam int XW = (CW > RANK_W) ? CW : RANK_W;

  logic [CW-1:0]          cnt_q, cnt_d;
  logic [QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]        fill_q;
  cmd_t                   q_cmd_q    [QUEUE_DEPTH];
  logic [KEY_BITS-1:0]    q_key_q    [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] q_handle_q [QUEUE_DEPTH];
  logic [CW-1:0]          q_cnt_q    [QUEUE_DEPTH];
  logic [AW-1:0]          q_addr_q   [QUEUE_DEPTH];

  logic    push, pop, full, hit;
  cmd_t    new_cmd;
  logic [AW-1:0] new_addr;

  assign in_stall_o = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = cmd_pop_i && cmd_valid_o;
  assign full       = (cnt_q == CW'(CAPACITY));
  assign hit        = (XW'(rank_i) < XW'(cnt_q));

  always_comb begin
    new_cmd       = '0;
    new_addr      = AW'(rank_i);
    cnt_d         = cnt_q;
    new_cmd.empty = (cnt_q == '0);
    if (func_i == FUNC_INSERT) begin
      new_cmd.last = batch_last_i;
      new_addr     = AW'(cnt_q - CW'(1));   // index of the last stored entry
      if (full) begin
        new_cmd.kind   = CMD_PLAIN;
        new_cmd.status = STAT_FULL;
      end else begin
        new_cmd.kind   = CMD_INSERT;
        new_cmd.status = STAT_OK;
        cnt_d          = cnt_q + CW'(1);
      end
    end else begin
      new_cmd.last = 1'b0;
      if (hit) begin
        new_cmd.kind   = CMD_READ;
        new_cmd.status = STAT_OK;
      end else begin
        new_cmd.kind   = CMD_PLAIN;
        new_cmd.status = STAT_MISS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        cnt_q    <= cnt_d;
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_cmd_q[wr_ptr_q]    <= new_cmd;
      q_key_q[wr_ptr_q]    <= KEY_BITS'(entry_key_i);
      q_handle_q[wr_ptr_q] <= HANDLE_BITS'(entry_handle_i);
      q_cnt_q[wr_ptr_q]    <= cnt_d;
      q_addr_q[wr_ptr_q]   <= new_addr;
    end
  end

  assign cmd_valid_o  = (fill_q != '0);
  assign cmd_o        = q_cmd_q[rd_ptr_q];
  assign cmd_key_o    = q_key_q[rd_ptr_q];
  assign cmd_handle_o = q_handle_q[rd_ptr_q];
  assign cmd_cnt_o    = q_cnt_q[rd_ptr_q];
  assign cmd_addr_o   = q_addr_q[rd_ptr_q];

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && full) |=> (cnt_q == CW'(CAPACITY)))
    else $error("count moved on a dropped insert");

endmodule

`default_nettype wire

### hdl/skit_back.sv
// skit_back: carries out queued commands on the entry memory and holds
// the result register; depends on skit_pkg and skit_ram
`timescale 1ns / 1ps
`default_nettype none

module skit_back
  import skit_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cmd_valid_i,
  output logic                        cmd_pop_o,
  input  wire cmd_t                   cmd_i,
  input  wire logic [KEY_BITS-1:0]    cmd_key_i,
  input  wire logic [HANDLE_BITS-1:0] cmd_handle_i,
  input  wire logic [CW-1:0]          cmd_cnt_i,
  input  wire logic [AW-1:0]          cmd_addr_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [HANDLE_BITS-1:0] out_handle_o,
  output logic      [KEY_BITS-1:0]    out_key_o,
  output status_e                     out_status_o,
  output logic      [CW-1:0]          out_cnt_o,
  output logic                        out_done_o
);

  localparam int DW = KEY_BITS + HANDLE_BITS;

  typedef enum logic [3:0] {
    BK_IDLE  = 4'b0001,
    BK_READ  = 4'b0010,
    BK_SCAN  = 4'b0100,
    BK_PLACE = 4'b1000
  } bk_state_e;

  bk_state_e state_q, state_d;
  logic [AW-1:0]          k_q, k_d;
  logic [KEY_BITS-1:0]    cur_key_q, cur_key_d;
  logic [HANDLE_BITS-1:0] cur_handle_q, cur_handle_d;
  logic [CW-1:0]          cur_cnt_q, cur_cnt_d;
  logic                   cur_last_q, cur_last_d;

  logic                   out_valid_q, out_valid_d;
  logic [HANDLE_BITS-1:0] out_handle_q, out_handle_d;
  logic [KEY_BITS-1:0]    out_key_q, out_key_d;
  status_e                out_status_q, out_status_d;
  logic [CW-1:0]          out_cnt_q, out_cnt_d;
  logic                   out_done_q, out_done_d;
  logic                   out_load;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [DW-1:0]          ram_wdata, ram_rdata;
  logic [KEY_BITS-1:0]    rd_key;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic                   slot_free;

  skit_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_key    = ram_rdata[DW-1:HANDLE_BITS];
  assign rd_handle = ram_rdata[HANDLE_BITS-1:0];
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    cur_key_d    = cur_key_q;
    cur_handle_d = cur_handle_q;
    cur_cnt_d    = cur_cnt_q;
    cur_last_d   = cur_last_q;
    cmd_pop_o    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = {cur_key_q, cur_handle_q};
    ram_raddr    = k_q - AW'(1);
    out_load     = 1'b0;
    out_handle_d = '0;
    out_key_d    = '0;
    out_status_d = STAT_OK;
    out_cnt_d    = cur_cnt_q;
    out_done_d   = cur_last_q;

    unique case (state_q)
      BK_IDLE: begin
        // a command is taken only when the result slot is free by the next edge
        if (cmd_valid_i && slot_free) begin
          cmd_pop_o    = 1'b1;
          cur_key_d    = cmd_key_i;
          cur_handle_d = cmd_handle_i;
          cur_cnt_d    = cmd_cnt_i;
          cur_last_d   = cmd_i.last;
          out_cnt_d    = cmd_cnt_i;
          out_done_d   = cmd_i.last;
          out_status_d = cmd_i.status;
          ram_raddr    = cmd_addr_i;
          unique case (cmd_i.kind)
            CMD_PLAIN: begin
              out_load = 1'b1;
            end
            CMD_READ: begin
              state_d = BK_READ;
            end
            CMD_INSERT: begin
              if (cmd_i.empty) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {cmd_key_i, cmd_handle_i};
                out_load  = 1'b1;
              end else begin
                k_d     = cmd_addr_i;
                state_d = BK_SCAN;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        out_load     = 1'b1;
        out_handle_d = rd_handle;
        out_key_d    = rd_key;
        state_d      = BK_IDLE;
      end
      BK_SCAN: begin
        // walk down from the top, moving larger keys up by one
        ram_we    = 1'b1;
        ram_waddr = k_q + AW'(1);
        if (rd_key > cur_key_q) begin
          ram_wdata = ram_rdata;
          if (k_q == '0) begin
            state_d = BK_PLACE;
          end else begin
            k_d = k_q - AW'(1);
          end
        end else begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      BK_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        out_load  = 1'b1;
        state_d   = BK_IDLE;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    cur_key_q    <= cur_key_d;
    cur_handle_q <= cur_handle_d;
    cur_cnt_q    <= cur_cnt_d;
    cur_last_q   <= cur_last_d;
    if (out_load) begin
      out_handle_q <= out_handle_d;
      out_key_q    <= out_key_d;
      out_status_q <= out_status_d;
      out_cnt_q    <= out_cnt_d;
      out_done_q   <= out_done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_handle_o = out_handle_q;
  assign out_key_o    = out_key_q;
  assign out_status_o = out_status_q;
  assign out_cnt_o    = out_cnt_q;
  assign out_done_o   = out_done_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("back end state not one-hot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !out_load)
    else $error("result loaded over a stalled result");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == BK_IDLE) && slot_free)
    else $error("command taken while busy");

  a_read_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_READ) |-> !ram_we)
    else $error("memory written during a rank read");

endmodule

`default_nettype wire

### hdl/sorted_key_insert_table_top.sv
// sorted_key_insert_table_top: sorted insertion priority list, top level
// holds skit_front and skit_back; depends on skit_pkg, skit_ram
//
// usage:
//   input channel in_valid_i / in_stall_o carries one item: func_i selects
//   an insert (entry_key_i, entry_handle_i, batch_last_i) or a rank read
//   (rank_i). output channel out_valid_o / out_stall_i returns one result
//   per item in order: handle and key on a read hit, a status code, the
//   entry count after the item and the batch marker of inserts.
//   entries live in one memory in ascending key order; equal keys keep
//   arrival order.
//   with an idle back end, a dropped insert, a rank miss or an insert
//   into an empty table passes through the command queue and then the
//   result register; a read hit goes through the queue, the memory read
//   and the result register. an insert walks the memory from the top
//   entry down, one entry per cycle; that walk over the single write port
//   sets the throughput of inserts. a two-entry command queue keeps
//   accepting items while the back end works.
//   reset clears the count and the queue at once; there is no clearing
//   pass, memory contents are only used below the count.
//   when out_stall_i is high the result is held, the back end stops after
//   its current command and in_stall_o rises once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_insert_table_top
  import skit_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                func_i,
  input  wire logic [KEY_W-1:0]    entry_key_i,
  input  wire logic [HANDLE_W-1:0] entry_handle_i,
  input  wire logic [RANK_W-1:0]   rank_i,
  input  wire logic                batch_last_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [HANDLE_W-1:0] out_handle_o,
  output logic      [KEY_W-1:0]    out_key_o,
  output logic      [1:0]          status_o,
  output logic      [COUNT_W-1:0]  entry_count_o,
  output logic                     batch_done_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                   cmd_valid, cmd_pop;
  cmd_t                   cmd;
  logic [KEY_BITS-1:0]    cmd_key;
  logic [HANDLE_BITS-1:0] cmd_handle;
  logic [CW-1:0]          cmd_cnt;
  logic [AW-1:0]          cmd_addr;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [KEY_BITS-1:0]    res_key;
  status_e                res_status;
  logic [CW-1:0]          res_cnt;

  skit_front #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .entry_key_i   (entry_key_i),
    .entry_handle_i(entry_handle_i),
    .rank_i        (rank_i),
    .batch_last_i  (batch_last_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop),
    .cmd_o         (cmd),
    .cmd_key_o     (cmd_key),
    .cmd_handle_o  (cmd_handle),
    .cmd_cnt_o     (cmd_cnt),
    .cmd_addr_o    (cmd_addr)
  );

  skit_back #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .cmd_key_i   (cmd_key),
    .cmd_handle_i(cmd_handle),
    .cmd_cnt_i   (cmd_cnt),
    .cmd_addr_i  (cmd_addr),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_handle_o(res_handle),
    .out_key_o   (res_key),
    .out_status_o(res_status),
    .out_cnt_o   (res_cnt),
    .out_done_o  (batch_done_o)
  );

  assign out_handle_o  = HANDLE_W'(res_handle);
  assign out_key_o     = KEY_W'(res_key);
  assign status_o      = res_status;
  assign entry_count_o = COUNT_W'(res_cnt);

endmodule

`default_nettype wire
